// ===== hw/rtl/xcfr_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// xcfr_pkg : shared types and constants of the frame receiver
// Phase and status codes, register indexes and the result record passed from
// the parser to the output register.
// ---------------------------------------------------------------------------
package xcfr_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CFG_IDX_W = 1;

  // reset values of the delimiter registers
  localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'h02;
  localparam logic [BYTE_W-1:0] END_BYTE_RST   = 8'h03;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_BYTE   = 1'b1;

  // receive phase
  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_LEN  = 3'd1,
    PH_DATA = 3'd2,
    PH_CHK  = 3'd3,
    PH_END  = 3'd4
  } phase_t;

  // per-item status
  typedef enum logic [1:0] {
    ST_PROGRESS = 2'd0,
    ST_OK       = 2'd1,
    ST_FAIL     = 2'd2
  } status_t;

  // one result item
  typedef struct packed {
    status_t           status;
    logic              payload_valid;
    logic [BYTE_W-1:0] payload_byte;
    logic [BYTE_W-1:0] payload_index;
  } result_t;

endpackage : xcfr_pkg
`default_nettype wire

// ===== hw/rtl/xcfr_parser.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// xcfr_parser : frame parsing state machine
// Holds phase, byte count, announced length and running checksum, and forms
// the result of each accepted byte in the same cycle.
// ---------------------------------------------------------------------------
module xcfr_parser
  import xcfr_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = 255
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire logic [BYTE_W-1:0] rx_byte,
  input  wire logic [BYTE_W-1:0] start_byte,
  input  wire logic [BYTE_W-1:0] end_byte,
  output result_t                res
);

  localparam logic [BYTE_W-1:0] MAX_LEN = BYTE_W'(MAX_PAYLOAD);

  phase_t            phase_r, phase_nxt;
  logic [BYTE_W-1:0] byte_count_r, byte_count_nxt;
  logic [BYTE_W-1:0] frame_length_r, frame_length_nxt;
  logic [BYTE_W-1:0] running_xor_r, running_xor_nxt;
  logic [BYTE_W-1:0] count_inc;

  assign count_inc = byte_count_r + 1'b1;

  // state register, advanced only on an accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_HUNT;
      byte_count_r   <= '0;
      frame_length_r <= '0;
      running_xor_r  <= '0;
    end else if (accept) begin
      phase_r        <= phase_nxt;
      byte_count_r   <= byte_count_nxt;
      frame_length_r <= frame_length_nxt;
      running_xor_r  <= running_xor_nxt;
    end
  end

  // next state and result
  always_comb begin
    phase_nxt         = phase_r;
    byte_count_nxt    = byte_count_r;
    frame_length_nxt  = frame_length_r;
    running_xor_nxt   = running_xor_r;
    res.status        = ST_PROGRESS;
    res.payload_valid = 1'b0;
    res.payload_byte  = '0;
    res.payload_index = '0;
    case (phase_r)
      PH_LEN: begin
        if (rx_byte > MAX_LEN) begin
          phase_nxt        = PH_HUNT;
          byte_count_nxt   = '0;
          frame_length_nxt = '0;
          running_xor_nxt  = '0;
          res.status       = ST_FAIL;
        end else begin
          frame_length_nxt = rx_byte;
          byte_count_nxt   = '0;
          running_xor_nxt  = '0;
          phase_nxt        = (rx_byte == '0) ? PH_CHK : PH_DATA;
        end
      end
      PH_DATA: begin
        res.payload_valid = 1'b1;
        res.payload_byte  = rx_byte;
        res.payload_index = byte_count_r;
        running_xor_nxt   = running_xor_r ^ rx_byte;
        byte_count_nxt    = count_inc;
        if (count_inc == frame_length_r) begin
          phase_nxt = PH_CHK;
        end
      end
      PH_CHK: begin
        if (rx_byte == running_xor_r) begin
          phase_nxt = PH_END;
        end else begin
          phase_nxt        = PH_HUNT;
          byte_count_nxt   = '0;
          frame_length_nxt = '0;
          running_xor_nxt  = '0;
          res.status       = ST_FAIL;
        end
      end
      PH_END: begin
        phase_nxt        = PH_HUNT;
        byte_count_nxt   = '0;
        frame_length_nxt = '0;
        running_xor_nxt  = '0;
        res.status       = (rx_byte == end_byte) ? ST_OK : ST_FAIL;
      end
      default: begin
        // hunting, and any stray code behaves as hunting
        phase_nxt        = (rx_byte == start_byte) ? PH_LEN : PH_HUNT;
        byte_count_nxt   = '0;
        frame_length_nxt = '0;
        running_xor_nxt  = '0;
      end
    endcase
  end

  // payload is only ever flagged while reading the data field
  assert property (@(posedge clk) disable iff (!rst_n)
    res.payload_valid |-> (phase_r == PH_DATA))
    else $error("payload flagged outside data phase");

  // a finished or failed frame always returns to hunting
  assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (res.status != ST_PROGRESS)) |=> (phase_r == PH_HUNT))
    else $error("no return to hunting after frame end");

  // the data phase never runs past the announced length
  assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (byte_count_r < frame_length_r))
    else $error("byte count overran frame length");

endmodule : xcfr_parser
`default_nettype wire

// ===== hw/rtl/xcfr_out_reg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// xcfr_out_reg : result register
// Holds one result item until taken; takes a new one in the cycle the held
// item leaves, so items flow one per cycle while out_ready is high.
// ---------------------------------------------------------------------------
module xcfr_out_reg
  import xcfr_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    load,
  input  wire result_t res,
  input  wire logic    out_ready,
  output logic         out_valid,
  output logic         free,
  output result_t      out_res
);

  logic    valid_r, valid_nxt;
  result_t res_r;

  // room for a new item when empty or when the held one leaves now
  assign free = !valid_r || out_ready;

  // valid flag
  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule : xcfr_out_reg
`default_nettype wire

// ===== hw/rtl/xor_checked_frame_receiver_core.sv =====
`default_nettype none
// latency: the result of a byte is shown on the cycle after it is accepted
// throughput: one byte per cycle while out_ready is high, bounded by the single result register
// in_ready stays high while the result register is empty or being emptied
// reset (rst_n low, synchronous): back to hunting, checksum, count and length
// cleared, start byte 0x02 and end byte 0x03, result register emptied
// ---------------------------------------------------------------------------
// xor_checked_frame_receiver_core : byte-wide framed receiver
// Hunts for a start byte, reads a length, passes payload bytes out while
// building an XOR checksum, then checks the checksum and end byte.
// ---------------------------------------------------------------------------
module xor_checked_frame_receiver_core
  import xcfr_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = 255
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // configuration
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [BYTE_W-1:0]    cfg_wdata,
  // input items
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [BYTE_W-1:0]    in_rx_byte,
  // result items
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [1:0]                out_status,
  output logic                      out_payload_valid,
  output logic [BYTE_W-1:0]         out_payload_byte,
  output logic [BYTE_W-1:0]         out_payload_index
);

  logic [BYTE_W-1:0] start_byte_r;
  logic [BYTE_W-1:0] end_byte_r;
  logic              accept;
  result_t           res;
  result_t           out_res;

  // delimiter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= START_BYTE_RST;
      end_byte_r   <= END_BYTE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_START_BYTE: start_byte_r <= cfg_wdata;
        CFG_END_BYTE:   end_byte_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign accept = in_valid && in_ready;

  // frame parser
  xcfr_parser #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .rx_byte    (in_rx_byte),
    .start_byte (start_byte_r),
    .end_byte   (end_byte_r),
    .res        (res)
  );

  // result register
  xcfr_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .res       (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .free      (in_ready),
    .out_res   (out_res)
  );

  assign out_status        = out_res.status;
  assign out_payload_valid = out_res.payload_valid;
  assign out_payload_byte  = out_res.payload_byte;
  assign out_payload_index = out_res.payload_index;

endmodule : xor_checked_frame_receiver_core
`default_nettype wire
